// ===== hw/rtl/csic_pkg.sv =====
package csic_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OUT_W   = 136;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'd44;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'd57;

    localparam int unsigned ROWS_LSB  = 0;
    localparam int unsigned FIRST_LSB = 32;
    localparam int unsigned LAST_LSB  = 64;
    localparam int unsigned GAP_LSB   = 96;
    localparam int unsigned BACK_BIT  = 128;
    localparam int unsigned CLEAN_BIT = 129;

    typedef logic [VALUE_W-1:0] t_value;

endpackage

// ===== hw/rtl/csv_sequence_index_checker.sv =====
// Sequence index checker for comma-separated text logs. Bytes of text enter on
// the s_axis side, one per cycle; s_axis_tlast marks the final byte. A line is
// a data row when its first kept character (of the first LINE_CHARS-1) is a
// digit and a comma follows within the kept characters; its first field is
// read as a decimal index modulo 2^32. After the final byte is processed one
// summary request leaves on m_axis: row count, first and last index, largest
// forward step, a backwards flag and a clean verdict, and all state clears.
// A trailing line without newline is not counted. Each byte passes through an
// input register into the per-byte update, and the summary of a final byte is
// held in a result register, so a byte can be accepted every cycle; only a
// final byte waits while an earlier summary is still held on m_axis.
module csv_sequence_index_checker #(
    parameter int unsigned LINE_CHARS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [csic_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic                         s_axis_tlast,  // end_of_text
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [31:0] row_count, [63:32] first_index, [95:64] last_index,
    // [127:96] largest_gap, [128] went_backwards, [129] is_clean, [135:130] zero
    output logic [csic_pkg::OUT_W-1:0]   m_axis_tdata
);
    import csic_pkg::*;

    localparam int unsigned POS_W = (LINE_CHARS > 2) ? $clog2(LINE_CHARS) : 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_CHARS - 1);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_starts, n_starts;
    logic              r_comma, n_comma;
    t_value            r_acc, n_acc;
    logic              r_have_prev, n_have_prev;
    t_value            r_prev, n_prev;
    t_value            r_first, n_first;
    t_value            r_rows, n_rows;
    t_value            r_gap, n_gap;
    logic              r_back, n_back;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [OUT_W-1:0]  n_out_data;

    logic              w_out_free;
    logic              w_proc;
    logic              w_newline;
    logic              w_digit;
    logic              w_row;
    t_value            w_step;
    logic              w_clean;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_newline = (r_in_byte == CHAR_NEWLINE);
    assign w_digit   = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign w_row     = w_newline && (r_pos != '0) && r_starts && r_comma;
    assign w_step    = r_acc - r_prev;

    always_comb begin
        n_pos       = r_pos;
        n_starts    = r_starts;
        n_comma     = r_comma;
        n_acc       = r_acc;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_first     = r_first;
        n_rows      = r_rows;
        n_gap       = r_gap;
        n_back      = r_back;
        if (w_newline) begin
            if (w_row) begin
                if (r_rows == '0) begin
                    n_first = r_acc;
                end
                if (r_have_prev) begin
                    if (r_acc < r_prev) begin
                        n_back = 1'b1;
                    end else if (w_step > r_gap) begin
                        n_gap = w_step;
                    end
                end
                n_prev      = r_acc;
                n_have_prev = 1'b1;
                n_rows      = r_rows + 32'd1;
            end
            n_pos    = '0;
            n_starts = 1'b0;
            n_comma  = 1'b0;
            n_acc    = '0;
        end else if (r_pos < POS_MAX) begin
            if (r_pos == '0) begin
                n_starts = w_digit;
            end
            if (!r_comma) begin
                if (r_in_byte == CHAR_COMMA) begin
                    n_comma = 1'b1;
                end else begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + VALUE_W'(r_in_byte)
                            - VALUE_W'(CHAR_ZERO);
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_comb begin
        w_clean = (n_rows != '0) && (n_first == '0) && (n_prev == n_rows - 32'd1)
                  && (n_gap <= 32'd1) && !n_back;
        n_out_data = '0;
        n_out_data[ROWS_LSB  +: VALUE_W] = n_rows;
        n_out_data[FIRST_LSB +: VALUE_W] = n_first;
        n_out_data[LAST_LSB  +: VALUE_W] = n_prev;
        n_out_data[GAP_LSB   +: VALUE_W] = n_gap;
        n_out_data[BACK_BIT]             = n_back;
        n_out_data[CLEAN_BIT]            = w_clean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_in_last)) begin
            r_pos       <= '0;
            r_starts    <= 1'b0;
            r_comma     <= 1'b0;
            r_acc       <= '0;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_first     <= '0;
            r_rows      <= '0;
            r_gap       <= '0;
            r_back      <= 1'b0;
        end else if (w_proc) begin
            r_pos       <= n_pos;
            r_starts    <= n_starts;
            r_comma     <= n_comma;
            r_acc       <= n_acc;
            r_have_prev <= n_have_prev;
            r_prev      <= n_prev;
            r_first     <= n_first;
            r_rows      <= n_rows;
            r_gap       <= n_gap;
            r_back      <= n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== hw/rtl/csic_checker.sv =====
module csic_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [csic_pkg::OUT_W-1:0]  m_axis_tdata
);
    import csic_pkg::*;

    logic   w_clean;
    logic   w_back;
    t_value w_rows;
    t_value w_first;
    t_value w_last;
    t_value w_gap;

    assign w_clean = m_axis_tdata[CLEAN_BIT];
    assign w_back  = m_axis_tdata[BACK_BIT];
    assign w_rows  = m_axis_tdata[ROWS_LSB  +: VALUE_W];
    assign w_first = m_axis_tdata[FIRST_LSB +: VALUE_W];
    assign w_last  = m_axis_tdata[LAST_LSB  +: VALUE_W];
    assign w_gap   = m_axis_tdata[GAP_LSB   +: VALUE_W];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("summary valid after reset");

    a_clean_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_clean |-> !w_back && (w_rows != '0) && (w_first == '0)
            && (w_last == w_rows - 32'd1) && (w_gap <= 32'd1))
        else $error("clean verdict disagrees with summary counts");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("summary dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("summary changed while stalled");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("request refused while summary side is free");

endmodule

bind csv_sequence_index_checker csic_checker u_csic_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/csv_sequence_index_checker_tb.sv =====
`timescale 1ns / 100ps

module csv_sequence_index_checker_tb;
    import csic_pkg::*;

    localparam int unsigned LINE_CHARS   = 64;
    localparam int unsigned TARGET_BYTES = 1450;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct {
        t_value row_count;
        t_value first_index;
        t_value last_index;
        t_value largest_gap;
        logic   went_backwards;
        logic   is_clean;
    } t_summary;

    typedef enum int {
        LINE_ROW,
        LINE_WIDE_INDEX,
        LINE_OVERLONG,
        LINE_STRAY_CHAR,
        LINE_NO_COMMA,
        LINE_TEXT_HEAD,
        LINE_EMPTY,
        LINE_NOISE
    } t_line_kind;

    class index_summary_tracker;
        int unsigned mismatches;
        int unsigned summaries_seen;
        int unsigned kept_chars;
        int unsigned line_pos;
        bit          lead_digit;
        bit          comma_found;
        bit          have_prev;
        bit          backwards;
        t_value      index_acc;
        t_value      prev_index;
        t_value      first_index;
        t_value      rows;
        t_value      gap_max;
        t_summary    pending[$];

        function new(int unsigned kept);
            kept_chars     = kept;
            mismatches     = 0;
            summaries_seen = 0;
            clear_all();
        endfunction

        function void clear_all();
            line_pos    = 0;
            lead_digit  = 1'b0;
            comma_found = 1'b0;
            index_acc   = '0;
            have_prev   = 1'b0;
            prev_index  = '0;
            first_index = '0;
            rows        = '0;
            gap_max     = '0;
            backwards   = 1'b0;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] ch, logic is_final);
            t_summary s;
            if (ch == CHAR_NEWLINE) begin
                if (line_pos != 0 && lead_digit && comma_found) begin
                    if (rows == 0) first_index = index_acc;
                    if (have_prev) begin
                        if (index_acc < prev_index) begin
                            backwards = 1'b1;
                        end else if (index_acc - prev_index > gap_max) begin
                            gap_max = index_acc - prev_index;
                        end
                    end
                    prev_index = index_acc;
                    have_prev  = 1'b1;
                    rows       = rows + 1;
                end
                line_pos    = 0;
                lead_digit  = 1'b0;
                comma_found = 1'b0;
                index_acc   = '0;
            end else if (line_pos < kept_chars) begin
                if (line_pos == 0) lead_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
                if (!comma_found) begin
                    if (ch == CHAR_COMMA) begin
                        comma_found = 1'b1;
                    end else begin
                        index_acc = index_acc * 10 + (t_value'(ch) - t_value'(CHAR_ZERO));
                    end
                end
                line_pos++;
            end
            if (is_final) begin
                s.row_count      = rows;
                s.first_index    = first_index;
                s.last_index     = prev_index;
                s.largest_gap    = gap_max;
                s.went_backwards = backwards;
                s.is_clean       = rows != 0 && first_index == 0 && prev_index == rows - 1
                                   && gap_max <= 1 && !backwards;
                pending.push_back(s);
                clear_all();
            end
        endfunction

        task report(string what);
            $display("summary %0d: %s", summaries_seen, what);
            mismatches++;
        endtask

        task compare(string name, t_value got, t_value want);
            if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_summary(logic [OUT_W-1:0] word);
            t_summary want;
            summaries_seen++;
            if (pending.size() == 0) begin
                report("arrived with none expected");
                return;
            end
            want = pending.pop_front();
            compare("row_count", word[ROWS_LSB +: VALUE_W], want.row_count);
            compare("first_index", word[FIRST_LSB +: VALUE_W], want.first_index);
            compare("last_index", word[LAST_LSB +: VALUE_W], want.last_index);
            compare("largest_gap", word[GAP_LSB +: VALUE_W], want.largest_gap);
            compare("went_backwards", t_value'(word[BACK_BIT]),
                    t_value'(want.went_backwards));
            compare("is_clean", t_value'(word[CLEAN_BIT]), t_value'(want.is_clean));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata;   // [7:0] data_byte
    logic               s_axis_tlast;   // end_of_text
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [31:0] row_count, [63:32] first_index, [95:64] last_index,
    // [127:96] largest_gap, [128] went_backwards, [129] is_clean
    logic [OUT_W-1:0]   m_axis_tdata;

    index_summary_tracker tracker;
    logic [BYTE_W-1:0]    frame_text[$];
    t_value               row_index;
    int unsigned          rows_in_frame;
    int unsigned          bytes_sent;
    int unsigned          cycle_count = 0;

    csv_sequence_index_checker #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) frame_text.push_back(s[i]);
    endfunction

    function automatic void append_digits(int unsigned n);
        repeat (n) frame_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void append_payload();
        frame_text.push_back(CHAR_COMMA);
        repeat ($urandom_range(0, 6)) frame_text.push_back(8'($urandom_range(32, 126)));
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte_except(logic [BYTE_W-1:0] a,
                                                         logic [BYTE_W-1:0] b,
                                                         bit no_digit);
        logic [BYTE_W-1:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == a || c == b || (no_digit && c >= CHAR_ZERO && c <= CHAR_NINE));
        return c;
    endfunction

    function automatic void advance_row_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (rows_in_frame == 0) begin
            if (r < 70) row_index = '0;
            else if (r < 85) row_index = t_value'($urandom_range(1, 20));
            else if (r < 90) row_index = '1;
            else row_index = t_value'($urandom);
        end else if (r < 65) begin
            row_index = row_index + 1;
        end else if (r < 73) begin
            row_index = row_index;
        end else if (r < 83) begin
            row_index = row_index + t_value'($urandom_range(2, 9));
        end else if (r < 93 && row_index != 0) begin
            row_index = t_value'($urandom_range(0, row_index - 1));
        end else begin
            row_index = t_value'($urandom);
        end
        rows_in_frame++;
    endfunction

    function automatic void compose_line(t_line_kind kind);
        case (kind)
            LINE_ROW: begin
                advance_row_index();
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 2)) frame_text.push_back(CHAR_ZERO);
                end
                append_text($sformatf("%0d", row_index));
                append_payload();
            end
            LINE_WIDE_INDEX: begin
                append_digits($urandom_range(11, 14));
                append_payload();
            end
            LINE_OVERLONG: begin
                append_digits($urandom_range(LINE_CHARS - 6, LINE_CHARS + 6));
                append_payload();
            end
            LINE_STRAY_CHAR: begin
                append_digits(1);
                frame_text.push_back(any_byte_except(CHAR_NEWLINE, CHAR_COMMA, 1'b0));
                append_digits($urandom_range(0, 3));
                append_payload();
            end
            LINE_NO_COMMA: begin
                append_digits($urandom_range(1, 6));
            end
            LINE_TEXT_HEAD: begin
                frame_text.push_back(any_byte_except(CHAR_NEWLINE, CHAR_NEWLINE, 1'b1));
                append_digits($urandom_range(0, 3));
                append_payload();
            end
            LINE_EMPTY: begin
            end
            default: begin
                repeat ($urandom_range(1, 12)) frame_text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        frame_text.push_back(CHAR_NEWLINE);
    endfunction

    function automatic t_line_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 62) return LINE_ROW;
        if (r < 68) return LINE_WIDE_INDEX;
        if (r < 72) return LINE_OVERLONG;
        if (r < 77) return LINE_STRAY_CHAR;
        if (r < 82) return LINE_NO_COMMA;
        if (r < 87) return LINE_TEXT_HEAD;
        if (r < 92) return LINE_EMPTY;
        return LINE_NOISE;
    endfunction

    function automatic void compose_random_frame();
        int unsigned n;
        rows_in_frame = 0;
        n = $urandom_range(0, 5);
        repeat (n) compose_line(pick_kind());
        if (n == 0 || $urandom_range(0, 9) < 4) begin
            repeat ($urandom_range(1, 5)) frame_text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b, logic is_final, bit steady);
        int unsigned gap;
        gap = steady ? 0 : pick_pause();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_final;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_byte(b, is_final);
    endtask

    task automatic send_frame();
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        foreach (frame_text[i]) send_byte(frame_text[i], i == frame_text.size() - 1, steady);
        bytes_sent += frame_text.size();
        frame_text.delete();
    endtask

    initial begin : summary_sink
        int unsigned stall;
        bit          steady;
        stall         = 0;
        steady        = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall = pick_pause();
            end
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                tracker.check_summary(m_axis_tdata);
                steady = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin : text_source
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_rst_n       = 1'b0;
        bytes_sent    = 0;
        row_index     = '0;
        rows_in_frame = 0;
        tracker       = new(LINE_CHARS - 1);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        append_text("0,a\n1,\n");
        send_frame();
        append_text("\n");
        send_frame();
        append_text("7,\n3,\n9");
        send_frame();
        append_text("0:,\n");
        frame_text.push_back(8'h00);
        frame_text.push_back(8'hFF);
        frame_text.push_back(8'h80);
        send_frame();

        compose_line(LINE_OVERLONG);
        compose_line(LINE_WIDE_INDEX);
        compose_line(LINE_ROW);
        send_frame();
        while (bytes_sent < TARGET_BYTES) begin
            compose_random_frame();
            send_frame();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
